FILE: sv/slm_pkg.sv
// shared types, constants and tables of the sound level meter
package slm_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int BSUM_W    = 41;
  localparam int CNT_W     = 11;
  localparam int ACC_W     = 56;
  localparam int DIV_W     = 57;
  localparam int DCNT_W    = 6;
  localparam int MS_FRAC   = 46;
  localparam int MAX_BLOCK = 1024;
  localparam int MAX_WIN   = 1024;
  localparam int POS_W     = 6;
  localparam int L2_W      = 24;
  localparam int DBP_W     = 43;
  localparam int RAW_W     = 19;
  localparam int EMA_W     = 38;
  localparam int SM_W      = 22;
  localparam int ALPHA_W   = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  localparam longint unsigned FLOOR_RAW =
    ((64'd1 << MS_FRAC) + 64'd5000000000) / 64'd10000000000;
  localparam logic [ACC_W-1:0] FLOOR_MS =
    (FLOOR_RAW == 0) ? ACC_W'(1) : ACC_W'(FLOOR_RAW);

  localparam logic signed [19:0] DB_PER_LOG2 = 20'sd197283;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd2;

  typedef struct packed {
    logic sample_step;
    logic blk_div_start;
    logic acc_update;
    logic win_div_start;
    logic floor_load;
    logic norm_shift;
    logic log_mul;
    logic l2_form;
    logic db_mul;
    logic raw_form;
    logic ema_mul1;
    logic ema_mul2;
    logic result_load;
  } slm_cmd_t;

  typedef struct packed {
    logic blk_end;
    logic div_done;
    logic window_full;
    logic norm_done;
    logic level_valid;
    logic out_free;
  } slm_stat_t;

  function automatic logic [16:0] log2_tab(input logic [4:0] idx);
    logic [16:0] v;
    unique case (idx)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [SM_W-1:0] v);
    logic signed [15:0] r;
    if (v > SM_W'(32767)) r = 16'sh7fff;
    else if (v < -SM_W'(32768)) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

FILE: sv/slm_div.sv
// restoring divider, one quotient bit per cycle
module slm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [slm_pkg::DIV_W-1:0]  dividend,
  input  logic [slm_pkg::CNT_W-1:0]  divisor,
  output logic [slm_pkg::DIV_W-1:0]  quotient,
  output logic                       done
);
  import slm_pkg::*;

  logic [CNT_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [CNT_W-1:0]  dvs;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic [CNT_W:0]    trial;
  logic              fit;

  assign trial = {rem, quo[DIV_W-1]};
  assign fit = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fit ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
      quo <= {quo[DIV_W-2:0], fit};
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) busy |-> rem < dvs)
    else $error("partial remainder not below divisor");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");

endmodule

FILE: sv/slm_dp.sv
// datapath: accumulators, shared divider, log2, dB scaling and smoothing
module slm_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  slm_pkg::slm_cmd_t                 cmd,
  output slm_pkg::slm_stat_t                stat,
  input  logic signed [slm_pkg::SAMPLE_W-1:0] sample,
  input  logic                              block_end,
  input  logic                              cfg_we,
  input  logic [slm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [slm_pkg::CFG_W-1:0]         cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                level_db
);
  import slm_pkg::*;

  logic [CNT_W-1:0]          window_blocks;
  logic signed [15:0]        mic_offset;
  logic [ALPHA_W-1:0]        smoothing_alpha;

  logic [BSUM_W-1:0]         bsum;
  logic [CNT_W-1:0]          bcnt;
  logic [ACC_W-1:0]          acc;
  logic [CNT_W-1:0]          wcnt;
  logic signed [15:0]        smoothed;
  logic                      level_valid;

  logic [ACC_W-1:0]          norm;
  logic [POS_W-1:0]          pos;
  logic [16:0]               base;
  logic [28:0]               mprod;
  logic signed [L2_W-1:0]    l2;
  logic signed [DBP_W-1:0]   dbprod;
  logic signed [RAW_W-1:0]   raw;
  logic signed [EMA_W-1:0]   m1;
  logic signed [EMA_W-1:0]   m2;

  logic                      div_start;
  logic [DIV_W-1:0]          div_dividend;
  logic [CNT_W-1:0]          div_divisor;
  logic [DIV_W-1:0]          quo;
  logic                      div_done;

  logic [31:0]               sq;
  logic [CNT_W-1:0]          bcnt_inc;
  logic [CNT_W-1:0]          win_eff;
  logic [ACC_W+1:0]          acc_sum;
  logic [CNT_W-1:0]          wcnt_inc;
  logic [4:0]                idx;
  logic [16:0]               tab_lo;
  logic [16:0]               tab_hi;
  logic [12:0]               diff;
  logic [ALPHA_W-1:0]        alpha_eff;
  logic signed [EMA_W-1:0]   ema_sum;
  logic signed [SM_W-1:0]    sm;
  logic signed [15:0]        result;

  assign sq       = 32'($signed(sample) * $signed(sample));
  assign bcnt_inc = bcnt + 1'b1;
  assign wcnt_inc = wcnt + 1'b1;
  assign acc_sum  = {2'b00, acc} + {1'b0, quo};

  always_comb begin
    if (window_blocks == '0) win_eff = CNT_W'(1);
    else if (window_blocks > CNT_W'(MAX_WIN)) win_eff = CNT_W'(MAX_WIN);
    else win_eff = window_blocks;
  end

  assign alpha_eff = (smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : smoothing_alpha;

  assign idx    = {1'b0, norm[ACC_W-2 -: 4]};
  assign tab_lo = log2_tab(idx);
  assign tab_hi = log2_tab(idx + 5'd1);
  assign diff   = 13'(tab_hi - tab_lo);

  assign ema_sum = m1 + m2;
  assign sm      = SM_W'((ema_sum + EMA_W'(32768)) >>> 16);
  assign result  = level_valid ? sat16(sm) : sat16(SM_W'(raw));

  assign div_start    = cmd.blk_div_start | cmd.win_div_start;
  assign div_dividend = cmd.blk_div_start ? DIV_W'({bsum, 16'd0}) : DIV_W'(acc);
  assign div_divisor  = cmd.blk_div_start ? bcnt : wcnt;

  slm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quo),
    .done     (div_done)
  );

  assign stat.blk_end     = block_end | (bcnt_inc >= CNT_W'(MAX_BLOCK));
  assign stat.div_done    = div_done;
  assign stat.window_full = wcnt >= win_eff;
  assign stat.norm_done   = norm[ACC_W-1];
  assign stat.level_valid = level_valid;
  assign stat.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_blocks   <= CNT_W'(8);
      mic_offset      <= 16'sd30720;
      smoothing_alpha <= ALPHA_W'(6554);
    end else if (cfg_we) begin
      if (cfg_index == CFG_WINDOW) window_blocks <= cfg_data[CNT_W-1:0];
      if (cfg_index == CFG_OFFSET) mic_offset <= cfg_data[15:0];
      if (cfg_index == CFG_ALPHA) smoothing_alpha <= cfg_data[ALPHA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bsum        <= '0;
      bcnt        <= '0;
      acc         <= '0;
      wcnt        <= '0;
      smoothed    <= '0;
      level_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.sample_step) begin
        bsum <= bsum + BSUM_W'(sq);
        bcnt <= bcnt_inc;
      end
      if (cmd.blk_div_start) begin
        bsum <= '0;
        bcnt <= '0;
      end
      if (cmd.acc_update) begin
        acc  <= (acc_sum[ACC_W+1:ACC_W] != 2'b00) ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
        wcnt <= wcnt_inc;
      end
      if (cmd.win_div_start) begin
        acc  <= '0;
        wcnt <= '0;
      end
      if (cmd.result_load) begin
        smoothed    <= result;
        level_valid <= 1'b1;
        out_valid   <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.floor_load) begin
      norm <= (quo[ACC_W-1:0] < FLOOR_MS) ? FLOOR_MS : quo[ACC_W-1:0];
      pos  <= POS_W'(ACC_W - 1);
    end else if (cmd.norm_shift) begin
      norm <= {norm[ACC_W-2:0], 1'b0};
      pos  <= pos - 1'b1;
    end
    if (cmd.log_mul) begin
      base  <= tab_lo;
      mprod <= 29'(diff * norm[ACC_W-6 -: 16]);
    end
    if (cmd.l2_form) begin
      l2 <= $signed(L2_W'({pos, 16'd0})) + $signed(L2_W'(base))
          + $signed(L2_W'(mprod[28:16])) - $signed(L2_W'(MS_FRAC * 65536));
    end
    if (cmd.db_mul) dbprod <= DBP_W'(l2 * DB_PER_LOG2);
    if (cmd.raw_form) begin
      raw <= RAW_W'((dbprod + DBP_W'(1 << 23)) >>> 24) + RAW_W'(mic_offset);
    end
    if (cmd.ema_mul1) m1 <= EMA_W'($signed({1'b0, alpha_eff}) * raw);
    if (cmd.ema_mul2) begin
      m2 <= EMA_W'($signed({1'b0, ALPHA_W'(ALPHA_ONE - alpha_eff)}) * smoothed);
    end
    if (cmd.result_load) level_db <= result;
  end

  assert property (@(posedge clk) disable iff (rst) bcnt <= CNT_W'(MAX_BLOCK))
    else $error("block sample count beyond limit");
  assert property (@(posedge clk) disable iff (rst) wcnt <= CNT_W'(MAX_WIN))
    else $error("window block count beyond limit");
  assert property (@(posedge clk) disable iff (rst) cmd.norm_shift |-> !norm[ACC_W-1])
    else $error("normalizing an already normalized value");
  assert property (@(posedge clk) disable iff (rst) cmd.result_load |-> !out_valid || out_ready)
    else $error("result overwrites a beat not yet taken");

endmodule

FILE: sv/slm_ctrl.sv
// controller state machine sequencing block, window and level steps
module slm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  slm_pkg::slm_stat_t stat,
  output slm_pkg::slm_cmd_t  cmd
);
  import slm_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BDIV  = 4'd1;
  localparam logic [3:0] S_BWAIT = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_WDIV  = 4'd4;
  localparam logic [3:0] S_WWAIT = 4'd5;
  localparam logic [3:0] S_NORM  = 4'd6;
  localparam logic [3:0] S_LOG   = 4'd7;
  localparam logic [3:0] S_L2    = 4'd8;
  localparam logic [3:0] S_DB    = 4'd9;
  localparam logic [3:0] S_RAW   = 4'd10;
  localparam logic [3:0] S_EMA1  = 4'd11;
  localparam logic [3:0] S_EMA2  = 4'd12;
  localparam logic [3:0] S_RES   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.sample_step = 1'b1;
          if (stat.blk_end) state_next = S_BDIV;
        end
      end
      S_BDIV: begin
        cmd.blk_div_start = 1'b1;
        state_next = S_BWAIT;
      end
      S_BWAIT: begin
        if (stat.div_done) begin
          cmd.acc_update = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = stat.window_full ? S_WDIV : S_IDLE;
      S_WDIV: begin
        cmd.win_div_start = 1'b1;
        state_next = S_WWAIT;
      end
      S_WWAIT: begin
        if (stat.div_done) begin
          cmd.floor_load = 1'b1;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (stat.norm_done) state_next = S_LOG;
        else cmd.norm_shift = 1'b1;
      end
      S_LOG: begin
        cmd.log_mul = 1'b1;
        state_next = S_L2;
      end
      S_L2: begin
        cmd.l2_form = 1'b1;
        state_next = S_DB;
      end
      S_DB: begin
        cmd.db_mul = 1'b1;
        state_next = S_RAW;
      end
      S_RAW: begin
        cmd.raw_form = 1'b1;
        state_next = stat.level_valid ? S_EMA1 : S_RES;
      end
      S_EMA1: begin
        cmd.ema_mul1 = 1'b1;
        state_next = S_EMA2;
      end
      S_EMA2: begin
        cmd.ema_mul2 = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.result_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assert property (@(posedge clk) disable iff (rst) stat.div_done |->
                   state == S_BWAIT || state == S_WWAIT)
    else $error("divider finished outside a wait state");
  assert property (@(posedge clk) disable iff (rst) cmd.blk_div_start |=> state == S_BWAIT)
    else $error("block divide not followed by wait");
  assert property (@(posedge clk) disable iff (rst) (state == S_RES && !stat.out_free) |=>
                   state == S_RES)
    else $error("result stage left while output is stalled");

endmodule

FILE: sv/sound_level_meter.sv
// top level of the sound level meter
// Input channel: in_valid/in_ready with sample (signed 16 bit) and block_end.
// Each beat adds sample^2 to the block sum; block_end, or the
// 1024th sample of a block, closes the block.
// Closing a block runs a bit-serial divide on the shared divider, so
// in_ready stays low after a block-end beat until the controller is idle again.
// When window_blocks blocks are gathered, a second divide on the shared
// divider, a normalize of up to 43 shifts, log2, dB scaling and smoothing
// (skipped for the first level) follow before the level beat.
// Output channel: out_valid/out_ready with level_db, one beat per window,
// held in an output register; samples keep flowing while it waits, and
// the next level result waits, with in_ready low, until the beat is taken.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 window_blocks,
// 1 mic offset, 2 smoothing_alpha); the user must write only when idle, the block does not enforce it.
// Reset (rst, synchronous) clears all sums, counts and the smoothing state
// and loads default register values; no result is pending after reset.
module sound_level_meter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [slm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                block_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [15:0]                  level_db,
  input  logic                                cfg_we,
  input  logic [slm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [slm_pkg::CFG_W-1:0]           cfg_data
);
  import slm_pkg::*;

  slm_cmd_t  cmd;
  slm_stat_t stat;

  slm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .sample    (sample),
    .block_end (block_end),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level_db  (level_db)
  );

endmodule
